// ----- hw/rtl/m68alu_pkg.sv -----
// Shared types, codes and helpers for the 68000-style ALU.
package m68alu_pkg;

   // Operation codes carried on the request channel
   typedef enum logic [3:0] {
      CMD_ADD  = 4'd0,
      CMD_SUB  = 4'd1,
      CMD_AND  = 4'd2,
      CMD_OR   = 4'd3,
      CMD_EOR  = 4'd4,
      CMD_NOT  = 4'd5,
      CMD_MULS = 4'd6,
      CMD_MULU = 4'd7,
      CMD_DIVS = 4'd8,
      CMD_DIVU = 4'd9
   } cmd_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Condition code bit positions (X N Z V C)
   localparam int CC_W = 5;
   localparam int CC_X = 4;
   localparam int CC_N = 3;
   localparam int CC_Z = 2;
   localparam int CC_V = 1;
   localparam int CC_C = 0;

   localparam int DATA_W   = 32;
   localparam int HALF_W   = 16;
   localparam int DIV_STEPS = DATA_W;
   localparam int CNT_W    = $clog2(DIV_STEPS);

   // Controller -> datapath commands
   typedef struct packed {
      logic load;      // capture request operands
      logic mul_step;  // register the 16x16 product
      logic div_step;  // one shift-subtract divide step
      logic finish;    // write result, flags and condition codes
   } dp_cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic is_mul;
      logic is_div;
      logic div_zero;
   } dp_status_type;

   // N and Z of a 32-bit value, returned as {n, z}
   function automatic logic [1:0] nz_of(logic [DATA_W-1:0] value);
      nz_of = {value[DATA_W-1], (value == '0)};
   endfunction

endpackage

// ----- hw/rtl/m68alu_ctrl.sv -----
// Controller state machine: sequences load, multiply, divide loop and result write.
module m68alu_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  m68alu_pkg::dp_status_type status,
   output m68alu_pkg::dp_cmd_type    cmd
);

   m68alu_pkg::state_type           state_ff, state_in;
   logic [m68alu_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                            out_valid_ff, out_valid_in;
   logic                            out_free;
   logic                            last_step;

   // Output register can take a new result when empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign last_step = (cnt_ff == m68alu_pkg::CNT_W'(m68alu_pkg::DIV_STEPS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         m68alu_pkg::ST_IDLE: begin
            if (req_valid) state_in = m68alu_pkg::ST_DISPATCH;
         end
         m68alu_pkg::ST_DISPATCH: begin
            if (status.is_div && !status.div_zero) state_in = m68alu_pkg::ST_DIV;
            else state_in = m68alu_pkg::ST_FINISH;
         end
         m68alu_pkg::ST_DIV: begin
            if (last_step) state_in = m68alu_pkg::ST_FINISH;
         end
         m68alu_pkg::ST_FINISH: begin
            if (out_free) state_in = m68alu_pkg::ST_IDLE;
         end
         default: state_in = m68alu_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         m68alu_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         m68alu_pkg::ST_DISPATCH: begin
            cmd.mul_step = status.is_mul;
            cnt_in       = '0;
         end
         m68alu_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
         end
         m68alu_pkg::ST_FINISH: begin
            cmd.finish = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Result valid: set on write, cleared on transfer
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (cmd.finish) out_valid_in = 1'b1;
   end

   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= m68alu_pkg::ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ----- hw/rtl/m68alu_dp.sv -----
// Datapath: operand registers, adder, logic, multiplier, divide loop, flags.
module m68alu_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  m68alu_pkg::dp_cmd_type    cmd,
   output m68alu_pkg::dp_status_type status,
   input  logic [3:0]                req_command,
   input  logic [31:0]               req_operand_a,
   input  logic [31:0]               req_operand_b,
   input  logic [31:0]               req_carry_addend,
   output logic [31:0]               rsp_result,
   output logic                      rsp_flag_x,
   output logic                      rsp_flag_n,
   output logic                      rsp_flag_z,
   output logic                      rsp_flag_v,
   output logic                      rsp_flag_c,
   output logic                      rsp_divide_by_zero
);

   localparam int DW = m68alu_pkg::DATA_W;
   localparam int HW = m68alu_pkg::HALF_W;
   localparam int CW = m68alu_pkg::CC_W;
   localparam logic [DW-1:0] SQ_POS_MAX = DW'((1 << (HW - 1)) - 1);
   localparam logic [DW-1:0] SQ_NEG_MAX = DW'(1 << (HW - 1));
   localparam logic [DW-1:0] UQ_MAX     = DW'((1 << HW) - 1);

   m68alu_pkg::cmd_type op_ff, op_in;
   logic [DW-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [HW-1:0] dvs_ff, dvs_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [HW-1:0] rem_ff, rem_in;
   logic          neg_q_ff, neg_q_in, neg_r_ff, neg_r_in, dz_ff, dz_in;
   logic [DW-1:0] prod_ff, prod_in;
   logic [CW-1:0] ccr_ff, ccr_in;
   logic [DW-1:0] res_ff, res_in;
   logic [CW-1:0] flags_ff, flags_in;
   logic          dzo_ff, dzo_in;

   // Load-time operand conditioning for divides
   logic          ld_signed;
   logic [HW-1:0] ld_dvs_raw, ld_dvs_abs;
   logic [DW-1:0] ld_dvd_abs;

   // Divide step
   logic [HW:0]   rem_sh, rem_diff;
   logic          quo_bit;

   // Multiply
   logic signed [HW:0]     mul_a, mul_b;
   logic signed [2*HW+1:0] mul_p;
   logic                   op_signed_mul;

   // Result and flag formation
   logic [DW-1:0] sum, diff, logic_r, qlo;
   logic [HW-1:0] rem_s;
   logic          v_div;
   logic [1:0]    nz;
   logic [DW-1:0] res_fin;
   logic [CW-1:0] cc_fin;
   logic          dz_fin;
   logic          xkeep;

   // Status to controller
   always_comb begin
      status.is_mul   = (op_ff == m68alu_pkg::CMD_MULS) || (op_ff == m68alu_pkg::CMD_MULU);
      status.is_div   = (op_ff == m68alu_pkg::CMD_DIVS) || (op_ff == m68alu_pkg::CMD_DIVU);
      status.div_zero = dz_ff;
   end

   // Divide operands: magnitudes for the signed case
   always_comb begin
      ld_signed  = (m68alu_pkg::cmd_type'(req_command) == m68alu_pkg::CMD_DIVS);
      ld_dvs_raw = req_operand_a[DW-1 -: HW];
      ld_dvs_abs = (ld_signed && ld_dvs_raw[HW-1]) ? (~ld_dvs_raw + 1'b1) : ld_dvs_raw;
      ld_dvd_abs = (ld_signed && req_operand_b[DW-1]) ? (~req_operand_b + 1'b1)
                                                       : req_operand_b;
   end

   // Restoring divide: one quotient bit per step
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[DW-1]};
      rem_diff = rem_sh - {1'b0, dvs_ff};
      quo_bit  = (rem_sh >= {1'b0, dvs_ff});
   end

   // 16x16 multiply, signed or unsigned through a 17-bit sign extension
   always_comb begin
      op_signed_mul = (op_ff == m68alu_pkg::CMD_MULS);
      mul_a = $signed({op_signed_mul & a_ff[DW-1], a_ff[DW-1 -: HW]});
      mul_b = $signed({op_signed_mul & b_ff[DW-1], b_ff[DW-1 -: HW]});
      mul_p = mul_a * mul_b;
   end

   // Final result and condition codes
   always_comb begin
      sum   = a_ff + b_ff + c_ff;
      diff  = a_ff - b_ff - c_ff;
      qlo   = neg_q_ff ? (~quo_ff + 1'b1) : quo_ff;
      rem_s = neg_r_ff ? (~rem_ff + 1'b1) : rem_ff;
      xkeep = ccr_ff[m68alu_pkg::CC_X];
      if (op_ff == m68alu_pkg::CMD_DIVS)
         v_div = neg_q_ff ? (quo_ff > SQ_NEG_MAX) : (quo_ff > SQ_POS_MAX);
      else
         v_div = (quo_ff > UQ_MAX);

      logic_r = '0;
      case (op_ff) inside
         m68alu_pkg::CMD_AND: logic_r = a_ff & b_ff;
         m68alu_pkg::CMD_OR:  logic_r = a_ff | b_ff;
         m68alu_pkg::CMD_EOR: logic_r = a_ff ^ b_ff;
         m68alu_pkg::CMD_NOT: logic_r = ~a_ff;
         m68alu_pkg::CMD_MULS,
         m68alu_pkg::CMD_MULU: logic_r = prod_ff;
         default: logic_r = '0;
      endcase

      res_fin = '0;
      cc_fin  = ccr_ff;
      dz_fin  = 1'b0;
      nz      = '0;
      case (op_ff) inside
         m68alu_pkg::CMD_ADD: begin
            res_fin = sum;
            nz      = m68alu_pkg::nz_of(sum);
            cc_fin  = '0;
            cc_fin[m68alu_pkg::CC_N] = nz[1];
            cc_fin[m68alu_pkg::CC_Z] = nz[0];
            cc_fin[m68alu_pkg::CC_C] = (a_ff[DW-1] & b_ff[DW-1])
                                     | (~sum[DW-1] & (a_ff[DW-1] | b_ff[DW-1]));
            cc_fin[m68alu_pkg::CC_X] = cc_fin[m68alu_pkg::CC_C];
            cc_fin[m68alu_pkg::CC_V] = (a_ff[DW-1] == b_ff[DW-1])
                                     && (sum[DW-1] != a_ff[DW-1]);
         end
         m68alu_pkg::CMD_SUB: begin
            res_fin = diff;
            nz      = m68alu_pkg::nz_of(diff);
            cc_fin  = '0;
            cc_fin[m68alu_pkg::CC_N] = nz[1];
            cc_fin[m68alu_pkg::CC_Z] = nz[0];
            cc_fin[m68alu_pkg::CC_C] = ((a_ff[DW-1] ^ ~diff[DW-1])
                                     & (b_ff[DW-1] ^ diff[DW-1])) ^ diff[DW-1];
            cc_fin[m68alu_pkg::CC_X] = cc_fin[m68alu_pkg::CC_C];
            cc_fin[m68alu_pkg::CC_V] = (a_ff[DW-1] ^ diff[DW-1])
                                     & (~b_ff[DW-1] ^ diff[DW-1]);
         end
         m68alu_pkg::CMD_AND, m68alu_pkg::CMD_OR, m68alu_pkg::CMD_EOR,
         m68alu_pkg::CMD_NOT, m68alu_pkg::CMD_MULS, m68alu_pkg::CMD_MULU: begin
            res_fin = logic_r;
            nz      = m68alu_pkg::nz_of(logic_r);
            cc_fin  = '0;
            cc_fin[m68alu_pkg::CC_X] = xkeep;
            cc_fin[m68alu_pkg::CC_N] = nz[1];
            cc_fin[m68alu_pkg::CC_Z] = nz[0];
         end
         m68alu_pkg::CMD_DIVS, m68alu_pkg::CMD_DIVU: begin
            if (dz_ff) begin
               // zero divisor: flags kept, dividend returned
               res_fin = b_ff;
               dz_fin  = 1'b1;
            end else begin
               nz      = m68alu_pkg::nz_of(qlo);
               cc_fin  = '0;
               cc_fin[m68alu_pkg::CC_X] = xkeep;
               cc_fin[m68alu_pkg::CC_N] = nz[1];
               cc_fin[m68alu_pkg::CC_Z] = nz[0];
               cc_fin[m68alu_pkg::CC_V] = v_div;
               res_fin = v_div ? b_ff : {rem_s, qlo[HW-1:0]};
            end
         end
         default: begin
            res_fin = '0;
         end
      endcase
   end

   // Next values of all datapath registers
   always_comb begin
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      dz_in    = dz_ff;
      prod_in  = prod_ff;
      ccr_in   = ccr_ff;
      res_in   = res_ff;
      flags_in = flags_ff;
      dzo_in   = dzo_ff;
      if (cmd.load) begin
         op_in    = m68alu_pkg::cmd_type'(req_command);
         a_in     = req_operand_a;
         b_in     = req_operand_b;
         c_in     = req_carry_addend;
         dvs_in   = ld_dvs_abs;
         quo_in   = ld_dvd_abs;
         rem_in   = '0;
         neg_q_in = ld_signed & (req_operand_b[DW-1] ^ req_operand_a[DW-1]);
         neg_r_in = ld_signed & req_operand_b[DW-1];
         dz_in    = (ld_dvs_raw == '0);
      end
      if (cmd.mul_step) prod_in = mul_p[DW-1:0];
      if (cmd.div_step) begin
         quo_in = {quo_ff[DW-2:0], quo_bit};
         rem_in = quo_bit ? rem_diff[HW-1:0] : rem_sh[HW-1:0];
      end
      if (cmd.finish) begin
         ccr_in   = cc_fin;
         res_in   = res_fin;
         flags_in = cc_fin;
         dzo_in   = dz_fin;
      end
   end

   // Condition code state
   always_ff @(posedge clock) begin
      if (reset) ccr_ff <= '0;
      else ccr_ff <= ccr_in;
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      dvs_ff   <= dvs_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      dz_ff    <= dz_in;
      prod_ff  <= prod_in;
      res_ff   <= res_in;
      flags_ff <= flags_in;
      dzo_ff   <= dzo_in;
   end

   assign rsp_result         = res_ff;
   assign rsp_flag_x         = flags_ff[m68alu_pkg::CC_X];
   assign rsp_flag_n         = flags_ff[m68alu_pkg::CC_N];
   assign rsp_flag_z         = flags_ff[m68alu_pkg::CC_Z];
   assign rsp_flag_v         = flags_ff[m68alu_pkg::CC_V];
   assign rsp_flag_c         = flags_ff[m68alu_pkg::CC_C];
   assign rsp_divide_by_zero = dzo_ff;

endmodule

// ----- hw/rtl/cpu68k_alu_with_condition_codes_top.sv -----
// Top level of the 68000-style ALU with condition codes.
//
//   channel   direction   handshake           payload
//   req_      in          req_valid/stall     command, operand_a, operand_b, carry_addend
//   rsp_      out         rsp_valid/stall     result, flag_x..flag_c, divide_by_zero
//
// Add, sub, logic, not and multiplies pass the dispatch and finish states before
// the result register is loaded; divides also run the 32-step shift-subtract loop,
// which produces one quotient bit per cycle. A zero divisor skips the loop. A new
// request is taken only once the result of the last one has been written.
// Reset is synchronous; it clears the condition codes and the controller.
// A new request is taken while a finished result still waits under rsp_stall;
// only the write of the following result waits for the output register.
module cpu68k_alu_with_condition_codes_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_command,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   input  logic [31:0] req_carry_addend,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result,
   output logic        rsp_flag_x,
   output logic        rsp_flag_n,
   output logic        rsp_flag_z,
   output logic        rsp_flag_v,
   output logic        rsp_flag_c,
   output logic        rsp_divide_by_zero
);

   m68alu_pkg::dp_cmd_type    dp_cmd;
   m68alu_pkg::dp_status_type dp_status;

   // Sequencer
   m68alu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // Arithmetic and flags
   m68alu_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .status             (dp_status),
      .req_command        (req_command),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .req_carry_addend   (req_carry_addend),
      .rsp_result         (rsp_result),
      .rsp_flag_x         (rsp_flag_x),
      .rsp_flag_n         (rsp_flag_n),
      .rsp_flag_z         (rsp_flag_z),
      .rsp_flag_v         (rsp_flag_v),
      .rsp_flag_c         (rsp_flag_c),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule

// ----- hw/rtl/m68alu_chk.sv -----
// Port-level checker for the ALU top level, with its bind.
module m68alu_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_result,
   input logic        rsp_flag_x,
   input logic        rsp_flag_n,
   input logic        rsp_flag_z,
   input logic        rsp_flag_v,
   input logic        rsp_flag_c,
   input logic        rsp_divide_by_zero
);

   // No result is offered right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result)
                                 && $stable({rsp_flag_x, rsp_flag_n, rsp_flag_z,
                                             rsp_flag_v, rsp_flag_c})
                                 && $stable(rsp_divide_by_zero))
      else $error("stalled result changed");

   // One item at a time: busy right after a request transfer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // Z and N always come from the same value, so never both set
   a_z_excludes_n: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flag_z |-> !rsp_flag_n)
      else $error("Z and N both set");

endmodule

bind cpu68k_alu_with_condition_codes_top m68alu_chk u_m68alu_chk (.*);

// ----- verif/cpu68k_alu_with_condition_codes_top_test.sv -----
// Self-checking test of the 68000-style ALU against a flag-tracking predictor.
`timescale 1ns / 100ps

typedef struct packed {
   logic [3:0]  cmd;
   logic [31:0] a;
   logic [31:0] b;
   logic [31:0] addend;
} alu_request_type;

typedef struct packed {
   logic [31:0] result;
   logic        x;
   logic        n;
   logic        z;
   logic        v;
   logic        c;
   logic        dz;
} alu_outcome_type;

// Tracks the condition codes and holds the outcomes still owed by the ALU
class alu_outcome_board;
   logic [m68alu_pkg::CC_W-1:0] cond_codes;
   alu_outcome_type             owed_outcomes[$];
   int                          errors;

   function new();
      cond_codes = '0;
      errors = 0;
   endfunction

   function int pending();
      return owed_outcomes.size();
   endfunction

   // Flags of logic ops, multiplies and divides: X kept, C cleared
   function logic [m68alu_pkg::CC_W-1:0] flags_keep_x(logic [31:0] value, logic ovf);
      logic [m68alu_pkg::CC_W-1:0] f;
      f = '0;
      f[m68alu_pkg::CC_X] = cond_codes[m68alu_pkg::CC_X];
      f[m68alu_pkg::CC_N] = value[31];
      f[m68alu_pkg::CC_Z] = (value == '0);
      f[m68alu_pkg::CC_V] = ovf;
      return f;
   endfunction

   // Work out the outcome of one accepted request and update the flags
   function void note_request(alu_request_type req);
      logic [31:0]                 r;
      logic [31:0]                 t;
      logic [m68alu_pkg::CC_W-1:0] nxt;
      logic                        dz;
      logic                        ovf;
      longint                      num;
      longint                      den;
      longint                      quo;
      longint                      rem;
      logic [31:0]                 uquo;
      logic [31:0]                 urem;
      int                          ma;
      int                          mb;
      alu_outcome_type             o;
      nxt = cond_codes;
      dz = 1'b0;
      r = '0;
      case (req.cmd)
         m68alu_pkg::CMD_ADD: begin
            r = req.a + req.b + req.addend;
            nxt = '0;
            nxt[m68alu_pkg::CC_N] = r[31];
            nxt[m68alu_pkg::CC_Z] = (r == '0);
            // carry from the sign bits only, so a wide addend's extra carry is lost
            nxt[m68alu_pkg::CC_C] = (req.a[31] & req.b[31])
                                  | (~r[31] & (req.a[31] | req.b[31]));
            nxt[m68alu_pkg::CC_X] = nxt[m68alu_pkg::CC_C];
            nxt[m68alu_pkg::CC_V] = (req.a[31] == req.b[31]) && (r[31] != req.a[31]);
         end
         m68alu_pkg::CMD_SUB: begin
            r = req.a - req.b - req.addend;
            nxt = '0;
            nxt[m68alu_pkg::CC_N] = r[31];
            nxt[m68alu_pkg::CC_Z] = (r == '0);
            t = ((req.a ^ ~r) & (req.b ^ r)) ^ r;
            nxt[m68alu_pkg::CC_C] = t[31];
            nxt[m68alu_pkg::CC_X] = t[31];
            t = (req.a ^ r) & (~req.b ^ r);
            nxt[m68alu_pkg::CC_V] = t[31];
         end
         m68alu_pkg::CMD_AND: begin
            r = req.a & req.b;
            nxt = flags_keep_x(r, 1'b0);
         end
         m68alu_pkg::CMD_OR: begin
            r = req.a | req.b;
            nxt = flags_keep_x(r, 1'b0);
         end
         m68alu_pkg::CMD_EOR: begin
            r = req.a ^ req.b;
            nxt = flags_keep_x(r, 1'b0);
         end
         m68alu_pkg::CMD_NOT: begin
            r = ~req.a;
            nxt = flags_keep_x(r, 1'b0);
         end
         m68alu_pkg::CMD_MULS: begin
            ma = $signed(req.a[31:16]);
            mb = $signed(req.b[31:16]);
            r = ma * mb;
            nxt = flags_keep_x(r, 1'b0);
         end
         m68alu_pkg::CMD_MULU: begin
            r = req.a[31:16] * req.b[31:16];
            nxt = flags_keep_x(r, 1'b0);
         end
         m68alu_pkg::CMD_DIVS: begin
            den = $signed(req.a[31:16]);
            if (den == 0) begin
               dz = 1'b1;
               r = req.b;
            end else begin
               // truncating division: remainder takes the dividend's sign
               num = $signed(req.b);
               quo = num / den;
               rem = num % den;
               ovf = (quo < -32768) || (quo > 32767);
               nxt = flags_keep_x(quo[31:0], ovf);
               r = ovf ? req.b : {rem[15:0], quo[15:0]};
            end
         end
         m68alu_pkg::CMD_DIVU: begin
            if (req.a[31:16] == '0) begin
               dz = 1'b1;
               r = req.b;
            end else begin
               uquo = req.b / {16'h0, req.a[31:16]};
               urem = req.b % {16'h0, req.a[31:16]};
               ovf = (uquo > 32'h0000_FFFF);
               nxt = flags_keep_x(uquo, ovf);
               r = ovf ? req.b : {urem[15:0], uquo[15:0]};
            end
         end
         default: r = '0;   // unused codes: no operation, flags kept
      endcase
      cond_codes = nxt;
      o.result = r;
      o.x = nxt[m68alu_pkg::CC_X];
      o.n = nxt[m68alu_pkg::CC_N];
      o.z = nxt[m68alu_pkg::CC_Z];
      o.v = nxt[m68alu_pkg::CC_V];
      o.c = nxt[m68alu_pkg::CC_C];
      o.dz = dz;
      owed_outcomes.push_back(o);
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, seen);
         errors++;
      end
   endfunction

   // Compare one accepted result with the oldest owed outcome
   function void check_response(alu_outcome_type seen);
      alu_outcome_type want;
      if (owed_outcomes.size() == 0) begin
         $display("%0t: result %h arrived with no request outstanding", $time, seen.result);
         errors++;
         return;
      end
      want = owed_outcomes.pop_front();
      compare_field("result", want.result, seen.result);
      compare_field("flag_x", want.x, seen.x);
      compare_field("flag_n", want.n, seen.n);
      compare_field("flag_z", want.z, seen.z);
      compare_field("flag_v", want.v, seen.v);
      compare_field("flag_c", want.c, seen.c);
      compare_field("divide_by_zero", want.dz, seen.dz);
   endfunction
endclass

module cpu68k_alu_with_condition_codes_top_test;

   localparam logic [3:0] CMD_FIRST_UNUSED = 4'd10;
   localparam logic [3:0] CMD_LAST_UNUSED  = 4'd15;
   localparam int RANDOM_ITEMS = 1525;
   localparam int DRAIN_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_command = '0;
   logic [31:0] req_operand_a = '0;
   logic [31:0] req_operand_b = '0;
   logic [31:0] req_carry_addend = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_result;
   logic        rsp_flag_x;
   logic        rsp_flag_n;
   logic        rsp_flag_z;
   logic        rsp_flag_v;
   logic        rsp_flag_c;
   logic        rsp_divide_by_zero;

   logic             draining = 1'b0;
   int               results_seen = 0;
   alu_outcome_board board = new();

   cpu68k_alu_with_condition_codes_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .req_carry_addend   (req_carry_addend),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result         (rsp_result),
      .rsp_flag_x         (rsp_flag_x),
      .rsp_flag_n         (rsp_flag_n),
      .rsp_flag_z         (rsp_flag_z),
      .rsp_flag_v         (rsp_flag_v),
      .rsp_flag_c         (rsp_flag_c),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one request and hold it until the transfer
   task automatic send_request(alu_request_type req);
      req_valid <= 1'b1;
      req_command <= req.cmd;
      req_operand_a <= req.a;
      req_operand_b <= req.b;
      req_carry_addend <= req.addend;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(req);
   endtask

   task automatic pause_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop offering and wait until every owed result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Corner values, MSB-aligned bytes and words, or anything
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return {8'($urandom_range(0, 255)), 24'h0};
         5: return {16'($urandom_range(0, 65535)), 16'h0};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_addend();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return 32'h0;
         4, 5: return 32'h1;
         6: return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // Random ops and unused codes, plus divides: mostly well-formed, the rest noise
   function automatic alu_request_type make_random_request();
      alu_request_type req;
      int unsigned     sel;
      int              sd;
      int              smag;
      int              squo;
      int              srem;
      int              sprod;
      int unsigned     ud;
      int unsigned     uquo;
      int unsigned     urem;
      req.a = pick_operand();
      req.b = pick_operand();
      req.addend = pick_addend();
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         req.cmd = CMD_FIRST_UNUSED + 4'($urandom_range(0, 5));
      end else if (sel < 50) begin
         req.cmd = 4'($urandom_range(0, 7));
      end else if (sel < 65) begin
         // quotient and remainder chosen first so the result fits
         req.cmd = m68alu_pkg::CMD_DIVS;
         sd = $urandom_range(1, 32767);
         if ($urandom_range(0, 1) != 0) sd = -sd;
         if ($urandom_range(0, 19) == 0) sd = -32768;
         smag = (sd < 0) ? -sd : sd;
         squo = int'($urandom_range(0, 65535)) - 32768;
         srem = $urandom_range(0, smag - 1);
         sprod = squo * sd;
         if (sprod < 0 || (sprod == 0 && $urandom_range(0, 1) != 0)) srem = -srem;
         req.a = {16'(sd), 16'($urandom)};
         req.b = sprod + srem;
      end else if (sel < 80) begin
         req.cmd = m68alu_pkg::CMD_DIVU;
         ud = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : $urandom_range(1, 65535);
         uquo = $urandom_range(0, 65535);
         urem = $urandom_range(0, ud - 1);
         req.a = {16'(ud), 16'($urandom)};
         req.b = uquo * ud + urem;
      end else begin
         req.cmd = ($urandom_range(0, 1) != 0) ? m68alu_pkg::CMD_DIVS : m68alu_pkg::CMD_DIVU;
         if ($urandom_range(0, 4) == 0) req.a = {16'h0, 16'($urandom)};
      end
      return req;
   endfunction

   // Run limit
   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   // Receiver: check transfers and stall on a pattern of its own
   initial begin
      alu_outcome_type observed;
      int              mode;
      int              mode_left;
      int              hold_left;
      logic            hold_done;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            observed.result = rsp_result;
            observed.x = rsp_flag_x;
            observed.n = rsp_flag_n;
            observed.z = rsp_flag_z;
            observed.v = rsp_flag_v;
            observed.c = rsp_flag_c;
            observed.dz = rsp_divide_by_zero;
            board.check_response(observed);
            results_seen++;
         end
         if (draining) begin
            rsp_stall <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!hold_done && results_seen >= 300) begin
            // long hold-off so the ALU backs up into its input
            hold_done = 1'b1;
            hold_left = 400;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(10, 120);
            end
            mode_left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Sender: reset, directed corners, then random bursts
   initial begin
      alu_request_type directed[$];
      int              sent;
      int              burst;
      logic            paused;
      directed.push_back('{m68alu_pkg::CMD_ADD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1});
      directed.push_back('{m68alu_pkg::CMD_AND,  32'hF0F0_F0F0, 32'hFF00_FF00, 32'h0});
      directed.push_back('{m68alu_pkg::CMD_ADD,  32'h0,         32'h0,         32'h0});
      directed.push_back('{m68alu_pkg::CMD_ADD,  32'h7FFF_FFFF, 32'h1,         32'h0});
      directed.push_back('{m68alu_pkg::CMD_ADD,  32'h8000_0000, 32'h8000_0000, 32'h0});
      directed.push_back('{m68alu_pkg::CMD_SUB,  32'h0,         32'h1,         32'h0});
      directed.push_back('{m68alu_pkg::CMD_SUB,  32'h8000_0000, 32'h1,         32'h0});
      directed.push_back('{m68alu_pkg::CMD_SUB,  32'h5,         32'h5,         32'h1});
      directed.push_back('{m68alu_pkg::CMD_ADD,  32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_FFFF});
      directed.push_back('{m68alu_pkg::CMD_OR,   32'h0,         32'h0,         32'h0});
      directed.push_back('{m68alu_pkg::CMD_EOR,  32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0});
      directed.push_back('{m68alu_pkg::CMD_NOT,  32'h0,         32'h1234_5678, 32'h0});
      directed.push_back('{m68alu_pkg::CMD_NOT,  32'hFFFF_FFFF, 32'h0,         32'h0});
      directed.push_back('{m68alu_pkg::CMD_MULS, 32'h8000_0000, 32'h8000_0000, 32'h0});
      directed.push_back('{m68alu_pkg::CMD_MULS, 32'hFFFF_0000, 32'h0001_0000, 32'h0});
      directed.push_back('{m68alu_pkg::CMD_MULU, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0});
      directed.push_back('{m68alu_pkg::CMD_DIVS, 32'h0007_0000, 32'hFFFF_FFEC, 32'h0});
      // most negative dividend over minus one
      directed.push_back('{m68alu_pkg::CMD_DIVS, 32'hFFFF_0000, 32'h8000_0000, 32'h0});
      directed.push_back('{m68alu_pkg::CMD_DIVS, 32'h0001_0000, 32'h0001_0000, 32'h0});
      directed.push_back('{m68alu_pkg::CMD_DIVS, 32'h0000_FFFF, 32'h0000_1234, 32'h0});
      directed.push_back('{m68alu_pkg::CMD_DIVU, 32'hFFFF_0000, 32'hFFFE_0001, 32'h0});
      directed.push_back('{m68alu_pkg::CMD_DIVU, 32'h0001_0000, 32'h0001_0000, 32'h0});
      directed.push_back('{m68alu_pkg::CMD_DIVU, 32'h0000_0000, 32'hDEAD_BEEF, 32'h0});
      directed.push_back('{CMD_FIRST_UNUSED, 32'h1234_5678, 32'h8765_4321, 32'h1});
      directed.push_back('{CMD_LAST_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_request(directed[i]);
      wait_for_results();

      sent = 0;
      paused = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            send_request(make_random_request());
            sent++;
         end
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            wait_for_results();
         end else if ($urandom_range(0, 3) != 0) begin
            pause_sender($urandom_range(1, 12));
         end
      end

      wait_for_results();
      draining = 1'b1;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
